// ===== rtl/core/anpt_pkg.sv =====
// Package: shared types, constants and CORDIC angle table for the arc projection block.
`timescale 1ns / 1ps
package anpt_pkg;
    localparam int MAX_STAGES = 24;
    localparam int VW = 36;
    localparam int RW = 37;
    localparam logic [63:0] INV_GAIN_Q30 = 64'd652032874;

    typedef enum logic [2:0] {
        REG_CORNER = 3'd0,
        REG_XL     = 3'd1,
        REG_XH     = 3'd2,
        REG_YL     = 3'd3,
        REG_YH     = 3'd4,
        REG_RAD    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic signed [VW-1:0] vx;
        logic signed [VW-1:0] vy;
        logic [31:0]          vz;
        logic                 vzero;
        logic signed [RW-1:0] rx;
        logic signed [RW-1:0] ry;
        logic signed [32:0]   rr;
        logic signed [16:0]   cx;
        logic signed [16:0]   cy;
        logic [15:0]          hdg;
        logic                 in_fence;
    } t_cell;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0: v = 32'h20000000;  1: v = 32'h12E4051E;  2: v = 32'h09FB385B;
            3: v = 32'h051111D4;  4: v = 32'h028B0D43;  5: v = 32'h0145D7E1;
            6: v = 32'h00A2F61E;  7: v = 32'h00517C55;  8: v = 32'h0028BE53;
            9: v = 32'h00145F2F;  10: v = 32'h000A2F98; 11: v = 32'h000517CC;
            12: v = 32'h00028BE6; 13: v = 32'h000145F3; 14: v = 32'h0000A2FA;
            15: v = 32'h0000517D; 16: v = 32'h000028BE; 17: v = 32'h0000145F;
            18: v = 32'h00000A30; 19: v = 32'h00000518; 20: v = 32'h0000028C;
            21: v = 32'h00000146; 22: v = 32'h000000A3; 23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction
endpackage

// ===== rtl/core/arc_nearest_point_tangent.sv =====
// Top level: arc projection with nearest point and tangent heading.
`timescale 1ns / 1ps
// Projects a pose onto a circle of the configured radius centred at a chosen
// fence corner and returns the arc point, the tangent heading nearest the
// vehicle heading, and an inside-fence flag. One pose is accepted per cycle
// while the pipeline is not stalled. A pose passes through one entry stage,
// one vectoring pass through the cell row, one rotation setup stage, one
// rotation pass through a second cell row, and one output stage. The pipeline
// stalls as a whole only when the output register is full and not taken.
module arc_nearest_point_tangent #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [15:0] i_pos_x,
    input  logic signed [15:0] i_pos_y,
    input  logic [15:0]        i_heading_in,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [15:0] o_near_x,
    output logic signed [15:0] o_near_y,
    output logic [15:0]        o_tangent_heading,
    output logic               o_inside_fence,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data
);
    localparam int N = (CORDIC_STAGES > anpt_pkg::MAX_STAGES) ?
                       anpt_pkg::MAX_STAGES : CORDIC_STAGES;
    localparam int VW = anpt_pkg::VW;
    localparam int RW = anpt_pkg::RW;

    logic [1:0] r_corner;
    logic signed [15:0] r_xl, r_xh, r_yl, r_yh;
    logic [14:0] r_rad;

    assign o_cfg_ready = i_rst_n;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner <= '0; r_xl <= '0; r_xh <= '0; r_yl <= '0; r_yh <= '0; r_rad <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                anpt_pkg::REG_CORNER: r_corner <= i_cfg_data[1:0];
                anpt_pkg::REG_XL:     r_xl <= i_cfg_data;
                anpt_pkg::REG_XH:     r_xh <= i_cfg_data;
                anpt_pkg::REG_YL:     r_yl <= i_cfg_data;
                anpt_pkg::REG_YH:     r_yh <= i_cfg_data;
                anpt_pkg::REG_RAD:    r_rad <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    // pipeline: stage 0 entry, 1..N vectoring, N+1 rotate setup, N+2..2N+1 rotating
    localparam int L = 2 * N + 2;
    logic [L-1:0] r_vld;
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en && i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // entry stage
    anpt_pkg::t_cell n_e, r_e;
    logic signed [16:0] w_cx, w_cy;
    logic signed [17:0] w_dx, w_dy;
    logic signed [VW-1:0] w_sx, w_sy;
    always_comb begin
        w_cx = r_corner[0] ? 17'(r_xh) : 17'(r_xl);
        w_cy = r_corner[1] ? 17'(r_yh) : 17'(r_yl);
        w_dx = 18'(i_pos_x) - 18'(w_cx);
        w_dy = 18'(i_pos_y) - 18'(w_cy);
        w_sx = VW'(w_dx) <<< 14;
        w_sy = VW'(w_dy) <<< 14;
        n_e = '0;
        n_e.vzero = (w_dx == 0) && (w_dy == 0);
        if (w_dx[17]) begin
            n_e.vx = -w_sx; n_e.vy = -w_sy; n_e.vz = 32'h80000000;
        end else begin
            n_e.vx = w_sx;  n_e.vy = w_sy;  n_e.vz = 32'h0;
        end
        n_e.cx = w_cx;
        n_e.cy = w_cy;
        n_e.hdg = i_heading_in;
        n_e.in_fence = (i_pos_x >= r_xl) && (i_pos_x <= r_xh) &&
                       (i_pos_y >= r_yl) && (i_pos_y <= r_yh);
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e <= n_e;
        end
    end

    anpt_pkg::t_cell w_v [0:N];
    assign w_v[0] = r_e;
    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_vec
            anpt_pkg::t_cell w_in;
            always_comb begin
                w_in = w_v[g];
                w_in.rr = '0;
            end
            anpt_pkg::t_cell w_out;
            anpt_cell #(.SHIFT(g)) u_cell (
                .i_clk(i_clk), .i_en(w_en), .i_d(w_in), .o_d(w_out));
            assign w_v[g+1] = w_out;
        end
    endgenerate

    // rotation setup
    anpt_pkg::t_cell n_s, r_s;
    logic [63:0] w_r0;
    logic [31:0] w_z, w_z2;
    always_comb begin
        n_s = w_v[N];
        w_z = w_v[N].vz;
        w_r0 = ({49'd0, r_rad} * anpt_pkg::INV_GAIN_Q30) >> 14;
        n_s.rx = RW'(w_r0);
        n_s.ry = '0;
        w_z2 = w_z;
        if ((w_z + 32'h40000000) >= 32'h80000000) begin
            n_s.rx = -RW'(w_r0);
            w_z2 = w_z - 32'h80000000;
        end
        n_s.rr = {w_z2[31], w_z2};
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s <= n_s;
        end
    end

    anpt_pkg::t_cell w_r [0:N];
    assign w_r[0] = r_s;
    generate
        for (g = 0; g < N; g++) begin : g_rot
            anpt_pkg::t_cell w_in;
            always_comb begin
                w_in = w_r[g];
                w_in.vx = '0;
                w_in.vy = '0;
                w_in.vzero = 1'b0;
            end
            anpt_pkg::t_cell w_out;
            anpt_pkg::t_cell w_nxt;
            anpt_cell #(.SHIFT(g)) u_cell (
                .i_clk(i_clk), .i_en(w_en), .i_d(w_in), .o_d(w_out));
            // the angle rides alongside the rotation unchanged
            logic [31:0] r_vz;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_vz <= w_r[g].vz;
                end
            end
            always_comb begin
                w_nxt = w_out;
                w_nxt.vz = r_vz;
            end
            assign w_r[g+1] = w_nxt;
        end
    endgenerate

    // output stage
    logic [15:0] w_a, w_d, w_tan;
    logic w_minus;
    logic [31:0] w_zr;
    logic signed [RW-1:0] w_rxr, w_ryr;
    logic signed [RW:0] w_nx, w_ny;
    always_comb begin
        w_zr = w_r[N].vz + 32'h8000;
        w_a  = w_zr[31:16];
        w_d  = w_r[N].hdg - w_a;
        if (!w_a[15]) w_minus = w_d > 16'd32768;
        else          w_minus = !((w_d != 0) && (w_d < 16'd32768));
        w_tan = w_minus ? (w_a - 16'd16384) : (w_a + 16'd16384);
        w_rxr = (w_r[N].rx + RW'(32768)) >>> 16;
        w_ryr = (w_r[N].ry + RW'(32768)) >>> 16;
        w_nx = (RW+1)'(w_r[N].cx) + (RW+1)'(w_rxr);
        w_ny = (RW+1)'(w_r[N].cy) + (RW+1)'(w_ryr);
    end

    function automatic logic [15:0] sat(input logic signed [RW:0] v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[15:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r_vld[L-1];
        end
        if (w_en) begin
            o_near_x <= sat(w_nx);
            o_near_y <= sat(w_ny);
            o_tangent_heading <= w_tan;
            o_inside_fence <= w_r[N].in_fence;
        end
    end
endmodule

// ===== rtl/core/anpt_cell.sv =====
// One CORDIC cell: a vectoring step and a rotation step side by side, one register stage.
`timescale 1ns / 1ps
module anpt_cell #(
    parameter int SHIFT = 0
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  anpt_pkg::t_cell     i_d,
    output anpt_pkg::t_cell     o_d
);
    logic [31:0] w_at;
    logic signed [anpt_pkg::VW-1:0] w_vxs, w_vys;
    logic signed [anpt_pkg::RW-1:0] w_rxs, w_rys;
    anpt_pkg::t_cell n_d, r_d;
    logic [31:0] w_vz;

    assign w_at  = anpt_pkg::atan_turn(SHIFT);
    assign w_vxs = i_d.vx >>> SHIFT;
    assign w_vys = i_d.vy >>> SHIFT;
    assign w_rxs = i_d.rx >>> SHIFT;
    assign w_rys = i_d.ry >>> SHIFT;

    // rotation steers by the sign of the residual angle rr carried in with the input
    always_comb begin
        n_d = i_d;
        if (!i_d.vy[anpt_pkg::VW-1]) begin
            n_d.vx = i_d.vx + w_vys;
            n_d.vy = i_d.vy - w_vxs;
            w_vz   = i_d.vz + w_at;
        end else begin
            n_d.vx = i_d.vx - w_vys;
            n_d.vy = i_d.vy + w_vxs;
            w_vz   = i_d.vz - w_at;
        end
        n_d.vz = i_d.vzero ? 32'd0 : w_vz;
        if (!i_d.rr[32]) begin
            n_d.rx = i_d.rx - w_rys;
            n_d.ry = i_d.ry + w_rxs;
            n_d.rr = i_d.rr - $signed({1'b0, w_at});
        end else begin
            n_d.rx = i_d.rx + w_rys;
            n_d.ry = i_d.ry - w_rxs;
            n_d.rr = i_d.rr + $signed({1'b0, w_at});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end
    assign o_d = r_d;
endmodule
